FILE: hw/rtl/pfdc_pkg.sv
`timescale 1ns / 1ps

package pfdc_pkg;

  // Operation codes carried in the kind field of a request.
  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_FWD   = 2'd1,
    KIND_COUNT = 2'd2
  } kind_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_DONE
  } ctrl_state_e;

  // Capacity after reset and saturation point of the match counter.
  localparam logic [6:0] CapReset = 7'd64;
  localparam logic [6:0] CountMax = 7'd127;

  // One stored packet.
  typedef struct packed {
    logic [15:0] source;
    logic [15:0] destination;
    logic [31:0] timestamp;
  } entry_t;

  // Request beat.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] source;
    logic [15:0] destination;
    logic [31:0] timestamp;
    logic [31:0] start_time;
    logic [31:0] end_time;
  } req_t;

  // Response beat.
  typedef struct packed {
    logic        accepted;
    logic        packet_valid;
    logic [15:0] out_source;
    logic [15:0] out_destination;
    logic [31:0] out_timestamp;
    logic [6:0]  match_count;
  } rsp_t;

  // Control from the sequencer to the compare unit.
  typedef struct packed {
    logic clear;
    logic en;
    logic count_mode;
  } cmp_ctl_t;

endpackage

FILE: hw/rtl/pfdc_chan_if.sv
`timescale 1ns / 1ps

// Valid/ready channel carrying one payload per beat.
interface pfdc_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/packet_fifo_dedup_count_top.sv
// Add and count scan the buffer: one store read per stored packet, a compare of the last
// entry read, a step to leave the scan and a commit that loads the response register.
// Forward reads the oldest packet, then fetches and commits; an empty forward or an unused
// kind goes straight to the commit. One request is in flight at a time; the commit waits
// for a free response register and the next beat is taken in the cycle after the commit.
// Reset (rst_ni low, asynchronous) empties the buffer and sets capacity to 64.
`timescale 1ns / 1ps

module packet_fifo_dedup_count_top
  import pfdc_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pfdc_chan_if.sink   req_i,
  pfdc_chan_if.source rsp_o,
  pfdc_chan_if.sink   cfg_i
);

  localparam int AW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);

  logic [6:0]    cap_q;
  logic [OW-1:0] cap_eff;
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic          re;
  logic [AW-1:0] raddr;
  entry_t        rdata;
  cmp_ctl_t      cmp_ctl;
  req_t          req_cur;
  logic          dup;
  logic [6:0]    count;

  // Capacity register; a write beat is always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_i.valid) begin
      cap_q <= cfg_i.payload;
    end
  end

  // Clamp capacity into 1..DEPTH.
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = OW'(1);
    end else if ({25'd0, cap_q} > 32'(DEPTH)) begin
      cap_eff = OW'(DEPTH);
    end else begin
      cap_eff = OW'(cap_q);
    end
  end

  pfdc_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .rsp_o     (rsp_o),
    .cap_i     (cap_eff),
    .we_o      (we),
    .waddr_o   (waddr),
    .wdata_o   (wdata),
    .re_o      (re),
    .raddr_o   (raddr),
    .rdata_i   (rdata),
    .cmp_ctl_o (cmp_ctl),
    .req_o     (req_cur),
    .dup_i     (dup),
    .count_i   (count)
  );

  pfdc_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pfdc_cmp u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (cmp_ctl),
    .req_i   (req_cur),
    .entry_i (rdata),
    .dup_o   (dup),
    .count_o (count)
  );

endmodule

FILE: hw/rtl/pfdc_store.sv
`timescale 1ns / 1ps

module pfdc_store
  import pfdc_pkg::*;
#(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/pfdc_cmp.sv
`timescale 1ns / 1ps

module pfdc_cmp
  import pfdc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmp_ctl_t   ctl_i,
  input  req_t       req_i,
  input  entry_t     entry_i,
  output logic       dup_o,
  output logic [6:0] count_o
);

  logic       same_pkt;
  logic       in_window;
  logic       dup_d, dup_q;
  logic [6:0] count_d, count_q;

  // Compare one stored entry against the request.
  assign same_pkt  = (entry_i.source == req_i.source) &&
                     (entry_i.destination == req_i.destination) &&
                     (entry_i.timestamp == req_i.timestamp);
  assign in_window = (entry_i.destination == req_i.destination) &&
                     (entry_i.timestamp >= req_i.start_time) &&
                     (entry_i.timestamp <= req_i.end_time);

  // Accumulate the duplicate flag or the saturating match count.
  always_comb begin
    dup_d   = dup_q;
    count_d = count_q;
    if (ctl_i.clear) begin
      dup_d   = 1'b0;
      count_d = '0;
    end else if (ctl_i.en) begin
      if (ctl_i.count_mode) begin
        if (in_window && (count_q != CountMax)) begin
          count_d = count_q + 7'd1;
        end
      end else if (same_pkt) begin
        dup_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dup_q   <= 1'b0;
      count_q <= '0;
    end else begin
      dup_q   <= dup_d;
      count_q <= count_d;
    end
  end

  assign dup_o   = dup_q;
  assign count_o = count_q;

endmodule

FILE: hw/rtl/pfdc_ctrl.sv
`timescale 1ns / 1ps

module pfdc_ctrl
  import pfdc_pkg::*;
#(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH),
  localparam int OW = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pfdc_chan_if.sink     req_i,
  pfdc_chan_if.source   rsp_o,
  input  logic [OW-1:0] cap_i,
  // Packet store.
  output logic          we_o,
  output logic [AW-1:0] waddr_o,
  output entry_t        wdata_o,
  output logic          re_o,
  output logic [AW-1:0] raddr_o,
  input  entry_t        rdata_i,
  // Compare unit.
  output cmp_ctl_t      cmp_ctl_o,
  output req_t          req_o,
  input  logic          dup_i,
  input  logic [6:0]    count_i
);

  localparam int SW = AW + 1;
  localparam logic [SW-1:0] DepthS = SW'(DEPTH);
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);

  ctrl_state_e   state_d, state_q;
  logic [AW-1:0] head_d, head_q;
  logic [OW-1:0] occ_d, occ_q;
  logic [AW-1:0] ptr_d, ptr_q;
  logic [OW-1:0] remain_d, remain_q;
  logic          rd_vld_d, rd_vld_q;
  req_t          req_d, req_q;
  rsp_t          rsp_d, rsp_q;
  logic          rsp_vld_d, rsp_vld_q;

  logic          load;
  logic          issue;
  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail;
  logic [OW-1:0] drop;
  logic [SW-1:0] head_drop_sum;
  logic [AW-1:0] head_drop;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] ptr_inc;

  // Ring arithmetic: slot after the newest packet, head after drops.
  assign tail_sum      = {1'b0, head_q} + SW'(occ_q);
  assign tail          = (tail_sum >= DepthS) ? AW'(tail_sum - DepthS) : AW'(tail_sum);
  assign drop          = occ_q - cap_i + OW'(1);
  assign head_drop_sum = {1'b0, head_q} + SW'(drop);
  assign head_drop     = (head_drop_sum >= DepthS) ? AW'(head_drop_sum - DepthS)
                                                   : AW'(head_drop_sum);
  assign head_inc      = (head_q == LastSlot) ? '0 : head_q + AW'(1);
  assign ptr_inc       = (ptr_q == LastSlot) ? '0 : ptr_q + AW'(1);

  assign issue = (remain_q != '0);
  assign load  = (state_q == ST_DONE) && (!rsp_vld_q || rsp_o.ready);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          unique case (req_i.payload.kind) inside
            KIND_ADD, KIND_COUNT: state_d = ST_SCAN;
            KIND_FWD:             state_d = (occ_q != '0) ? ST_FETCH : ST_DONE;
            default:              state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (!issue && !rd_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_FETCH: state_d = ST_DONE;
      ST_DONE: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    head_d    = head_q;
    occ_d     = occ_q;
    ptr_d     = ptr_q;
    remain_d  = remain_q;
    rd_vld_d  = 1'b0;
    req_d     = req_q;
    rsp_d     = rsp_q;
    rsp_vld_d = rsp_vld_q;
    re_o      = 1'b0;
    raddr_o   = ptr_q;
    we_o      = 1'b0;
    cmp_ctl_o = '0;
    cmp_ctl_o.count_mode = (req_q.kind == KIND_COUNT);

    // The response leaves when its beat is taken.
    if (rsp_vld_q && rsp_o.ready) begin
      rsp_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          req_d           = req_i.payload;
          ptr_d           = head_q;
          cmp_ctl_o.clear = 1'b1;
          // Only add and count walk the stored packets.
          if ((req_i.payload.kind == KIND_ADD) || (req_i.payload.kind == KIND_COUNT)) begin
            remain_d = occ_q;
          end else begin
            remain_d = '0;
          end
          if ((req_i.payload.kind == KIND_FWD) && (occ_q != '0)) begin
            re_o    = 1'b1;
            raddr_o = head_q;
          end
        end
      end
      // Walk the occupied slots oldest first, one read per cycle.
      ST_SCAN: begin
        cmp_ctl_o.en = rd_vld_q;
        if (issue) begin
          re_o     = 1'b1;
          rd_vld_d = 1'b1;
          ptr_d    = ptr_inc;
          remain_d = remain_q - OW'(1);
        end
      end
      ST_FETCH: begin
      end
      // Commit the operation and load the response register.
      ST_DONE: begin
        if (load) begin
          rsp_d     = '0;
          rsp_vld_d = 1'b1;
          case (req_q.kind)
            KIND_ADD: begin
              rsp_d.accepted = !dup_i;
              if (!dup_i) begin
                we_o = 1'b1;
                if (occ_q >= cap_i) begin
                  head_d = head_drop;
                  occ_d  = cap_i;
                end else begin
                  occ_d = occ_q + OW'(1);
                end
              end
            end
            KIND_FWD: begin
              if (occ_q != '0) begin
                rsp_d.packet_valid    = 1'b1;
                rsp_d.out_source      = rdata_i.source;
                rsp_d.out_destination = rdata_i.destination;
                rsp_d.out_timestamp   = rdata_i.timestamp;
                head_d                = head_inc;
                occ_d                 = occ_q - OW'(1);
              end
            end
            KIND_COUNT: rsp_d.match_count = count_i;
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  assign waddr_o             = tail;
  assign wdata_o.source      = req_q.source;
  assign wdata_o.destination = req_q.destination;
  assign wdata_o.timestamp   = req_q.timestamp;
  assign req_o               = req_q;

  assign req_i.ready   = (state_q == ST_IDLE);
  assign rsp_o.valid   = rsp_vld_q;
  assign rsp_o.payload = rsp_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      occ_q     <= '0;
      ptr_q     <= '0;
      remain_q  <= '0;
      rd_vld_q  <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      occ_q     <= occ_d;
      ptr_q     <= ptr_d;
      remain_q  <= remain_d;
      rd_vld_q  <= rd_vld_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
  end

`ifndef SYNTHESIS
  // The buffer never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) occ_q <= OW'(DEPTH))
    else $error("occupancy above depth");

  // A scan never runs past the number of stored packets.
  assert property (@(posedge clk_i) disable iff (!rst_ni) remain_q <= occ_q)
    else $error("scan count above occupancy");

  // A stored packet leaves the buffer non-empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (req_q.kind == KIND_ADD) && !dup_i) |=> (occ_q != '0))
    else $error("add left buffer empty");

  // A forward that returns a packet removes exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (req_q.kind == KIND_FWD) && (occ_q != '0)) |=>
      (occ_q == $past(occ_q) - OW'(1)))
    else $error("forward did not pop one packet");
`endif

endmodule
